// ----- hw/rtl/vbp_pkg.sv -----
// vbp_pkg: shared constants, codes and types of the voxel bit-plane plotter
// no dependencies; used by every module under hw/rtl
`timescale 1ns / 1ps

package vbp_pkg;

    localparam int GRID_X_DEFAULT = 128;
    localparam int GRID_Y_DEFAULT = 128;
    localparam int SLICES_DEFAULT = 3;

    localparam int SLICE_DEPTH    = 24;
    localparam int BITS_PER_COLOR = 8;
    localparam int WORD_W         = 24;

    // widest store address over the whole parameter range
    localparam int ADDR_MAX_W  = 23;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [31:0] SCALE_RESET = 32'h0001_0000;

    typedef enum logic [2:0] {
        CFG_OFFSET_X  = 3'd0,
        CFG_OFFSET_Y  = 3'd1,
        CFG_OFFSET_Z  = 3'd2,
        CFG_SCALE_X   = 3'd3,
        CFG_SCALE_Y   = 3'd4,
        CFG_SCALE_Z   = 3'd5,
        CFG_SWAP_MODE = 3'd6,
        CFG_FLIP_MODE = 3'd7
    } cfg_index_t;

    typedef enum logic {
        REQ_PLOT = 1'b0,
        REQ_READ = 1'b1
    } req_kind_t;

    typedef enum logic [1:0] {
        CMD_ZERO = 2'd0,
        CMD_READ = 2'd1,
        CMD_PLOT = 2'd2
    } cmd_kind_t;

    typedef enum logic [1:0] {
        BK_CLEAR  = 2'd0,
        BK_IDLE   = 2'd1,
        BK_ACCESS = 2'd2
    } back_state_t;

    typedef struct packed {
        cmd_kind_t               kind;
        logic [ADDR_MAX_W-1:0]   addr;
        logic [WORD_W-1:0]       front_bits;
        logic [WORD_W-1:0]       back_bits;
    } cmd_t;

endpackage

// ----- hw/rtl/vbp_front.sv -----
// vbp_front: request pipeline - axis swap, offset, scale, range check, flip
// and depth split into store address and bit masks; depends on vbp_pkg
`timescale 1ns / 1ps

module vbp_front #(
    parameter int GRID_X = vbp_pkg::GRID_X_DEFAULT,
    parameter int GRID_Y = vbp_pkg::GRID_Y_DEFAULT,
    parameter int SLICES = vbp_pkg::SLICES_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                req_type,
    input  logic signed [31:0]  coord_x,
    input  logic signed [31:0]  coord_y,
    input  logic signed [31:0]  coord_z,
    input  logic [1:0]          read_slice,
    input  logic [6:0]          read_col,
    input  logic [6:0]          read_row,
    input  logic signed [31:0]  offset_x,
    input  logic signed [31:0]  offset_y,
    input  logic signed [31:0]  offset_z,
    input  logic [31:0]         scale_x,
    input  logic [31:0]         scale_y,
    input  logic [31:0]         scale_z,
    input  logic [2:0]          swap_mode,
    input  logic [2:0]          flip_mode,
    input  logic                clear_busy,
    output logic                push_valid,
    input  logic                push_ready,
    output vbp_pkg::cmd_t       push_data
);

    localparam int DEPTH_TOTAL = SLICES * vbp_pkg::SLICE_DEPTH;
    localparam int XW = $clog2(GRID_X);
    localparam int YW = $clog2(GRID_Y);
    localparam int ZW = $clog2(DEPTH_TOTAL);
    localparam int AW = $clog2(SLICES * GRID_Y * GRID_X);
    localparam int CW = $clog2(vbp_pkg::BITS_PER_COLOR);

    localparam logic [31:0] GX32 = 32'(GRID_X);
    localparam logic [31:0] GY32 = 32'(GRID_Y);
    localparam logic [31:0] GZ32 = 32'(DEPTH_TOTAL);
    localparam logic [31:0] GS32 = 32'(SLICES);

    localparam logic [XW-1:0] X_MAX = XW'(GRID_X - 1);
    localparam logic [YW-1:0] Y_MAX = YW'(GRID_Y - 1);
    localparam logic [ZW-1:0] Z_MAX = ZW'(DEPTH_TOTAL - 1);

    localparam logic [AW-1:0] ROW_WORDS   = AW'(GRID_X);
    localparam logic [AW-1:0] PLANE_WORDS = AW'(GRID_X * GRID_Y);

    // divide by three for values below 512
    localparam logic [15:0] DIV3_MUL   = 16'd171;
    localparam int          DIV3_SHIFT = 9;

    localparam logic [1:0] GRP_BLUE = 2'd0;
    localparam logic [1:0] GRP_RED  = 2'd1;

    logic                adv;
    logic                in_fire;

    logic signed [31:0]  sw_y1;
    logic signed [31:0]  sw_z1;
    logic signed [31:0]  sw_x2;
    logic signed [31:0]  sw_z2;
    logic signed [31:0]  sw_x3;
    logic signed [31:0]  sw_y3;

    logic                s1_valid_reg;
    logic                s1_req_reg;
    logic signed [31:0]  s1_x_reg;
    logic signed [31:0]  s1_y_reg;
    logic signed [31:0]  s1_z_reg;
    logic [1:0]          s1_slice_reg;
    logic [6:0]          s1_col_reg;
    logic [6:0]          s1_row_reg;

    logic                s2_valid_reg;
    logic                s2_req_reg;
    logic [32:0]         s2_dx_reg;
    logic [32:0]         s2_dy_reg;
    logic [32:0]         s2_dz_reg;
    logic [1:0]          s2_slice_reg;
    logic [6:0]          s2_col_reg;
    logic [6:0]          s2_row_reg;

    logic [63:0]         prod_x;
    logic [63:0]         prod_y;
    logic [63:0]         prod_z;

    logic                s3_valid_reg;
    logic                s3_req_reg;
    logic [31:0]         s3_qx_reg;
    logic [31:0]         s3_qy_reg;
    logic [31:0]         s3_qz_reg;
    logic [1:0]          s3_slice_reg;
    logic [6:0]          s3_col_reg;
    logic [6:0]          s3_row_reg;

    logic                in_x;
    logic                in_y;
    logic                in_z;
    logic                rd_ok;
    logic [XW-1:0]       x0;
    logic [YW-1:0]       y0;
    logic [ZW-1:0]       z0;
    logic [XW-1:0]       xf;
    logic [YW-1:0]       yf;
    logic [ZW-1:0]       zf;
    logic [7:0]          w8;
    logic [15:0]         slice_prod;
    logic [7:0]          slice8;
    logic [7:0]          group8;
    logic [CW-1:0]       bitpos;
    logic [7:0]          fbit;
    logic [7:0]          bbit;
    logic [AW-1:0]       sel_s;
    logic [AW-1:0]       sel_y;
    logic [AW-1:0]       sel_x;
    logic [AW-1:0]       addr;

    assign adv      = !s3_valid_reg || push_ready;
    assign in_ready = adv && !clear_busy;
    assign in_fire  = in_valid && in_ready;

    // swap yz, then xz, then xy
    assign sw_y1 = swap_mode[0] ? coord_z : coord_y;
    assign sw_z1 = swap_mode[0] ? coord_y : coord_z;
    assign sw_x2 = swap_mode[1] ? sw_z1 : coord_x;
    assign sw_z2 = swap_mode[1] ? coord_x : sw_z1;
    assign sw_x3 = swap_mode[2] ? sw_y1 : sw_x2;
    assign sw_y3 = swap_mode[2] ? sw_x2 : sw_y1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_fire;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_req_reg   <= req_type;
            s1_x_reg     <= sw_x3;
            s1_y_reg     <= sw_y3;
            s1_z_reg     <= sw_z2;
            s1_slice_reg <= read_slice;
            s1_col_reg   <= read_col;
            s1_row_reg   <= read_row;

            s2_req_reg   <= s1_req_reg;
            s2_dx_reg    <= {s1_x_reg[31], s1_x_reg} - {offset_x[31], offset_x};
            s2_dy_reg    <= {s1_y_reg[31], s1_y_reg} - {offset_y[31], offset_y};
            s2_dz_reg    <= {s1_z_reg[31], s1_z_reg} - {offset_z[31], offset_z};
            s2_slice_reg <= s1_slice_reg;
            s2_col_reg   <= s1_col_reg;
            s2_row_reg   <= s1_row_reg;

            s3_req_reg   <= s2_req_reg;
            s3_qx_reg    <= (!s2_dx_reg[32] && (s2_dx_reg[31:0] != 32'd0)) ? prod_x[63:32] : '0;
            s3_qy_reg    <= (!s2_dy_reg[32] && (s2_dy_reg[31:0] != 32'd0)) ? prod_y[63:32] : '0;
            s3_qz_reg    <= (!s2_dz_reg[32] && (s2_dz_reg[31:0] != 32'd0)) ? prod_z[63:32] : '0;
            s3_slice_reg <= s2_slice_reg;
            s3_col_reg   <= s2_col_reg;
            s3_row_reg   <= s2_row_reg;
        end
    end

    // a positive difference fits in 32 bits unsigned
    assign prod_x = s2_dx_reg[31:0] * scale_x;
    assign prod_y = s2_dy_reg[31:0] * scale_y;
    assign prod_z = s2_dz_reg[31:0] * scale_z;

    // classify the item leaving the pipeline
    assign in_x = (s3_qx_reg != 32'd0) && (s3_qx_reg <= GX32);
    assign in_y = (s3_qy_reg != 32'd0) && (s3_qy_reg <= GY32);
    assign in_z = (s3_qz_reg != 32'd0) && (s3_qz_reg <= GZ32);

    assign rd_ok = (32'(s3_slice_reg) < GS32) && (32'(s3_col_reg) < GX32)
                   && (32'(s3_row_reg) < GY32);

    assign x0 = XW'(s3_qx_reg - 32'd1);
    assign y0 = YW'(s3_qy_reg - 32'd1);
    assign z0 = ZW'(s3_qz_reg - 32'd1);

    assign xf = flip_mode[0] ? (X_MAX - x0) : x0;
    assign yf = flip_mode[1] ? (Y_MAX - y0) : y0;
    assign zf = flip_mode[2] ? (Z_MAX - z0) : z0;

    // depth split: eight bits per colour group, three groups per slice
    assign w8         = 8'(zf >> CW);
    assign slice_prod = 16'(w8) * DIV3_MUL;
    assign slice8     = 8'(slice_prod >> DIV3_SHIFT);
    assign group8     = w8 - 8'(slice8 * 8'd3);
    assign bitpos     = zf[CW-1:0];

    assign fbit = 8'd1 << bitpos;
    assign bbit = (bitpos == '0) ? 8'd0 : (8'd1 << CW'(CW'(0) - bitpos));

    always_comb
    begin
        if (s3_req_reg == vbp_pkg::REQ_READ)
        begin
            sel_s = AW'(s3_slice_reg);
            sel_y = AW'(s3_row_reg);
            sel_x = AW'(s3_col_reg);
        end
        else
        begin
            sel_s = AW'(slice8);
            sel_y = AW'(yf);
            sel_x = AW'(xf);
        end
    end

    assign addr = sel_s * PLANE_WORDS + sel_y * ROW_WORDS + sel_x;

    always_comb
    begin
        push_data.addr       = vbp_pkg::ADDR_MAX_W'(addr);
        push_data.front_bits = '0;
        push_data.back_bits  = '0;
        if (s3_req_reg == vbp_pkg::REQ_READ)
        begin
            push_data.kind = rd_ok ? vbp_pkg::CMD_READ : vbp_pkg::CMD_ZERO;
        end
        else
        begin
            push_data.kind = (in_x && in_y && in_z) ? vbp_pkg::CMD_PLOT : vbp_pkg::CMD_ZERO;
            case (group8[1:0])
                GRP_BLUE:
                begin
                    push_data.front_bits = {16'd0, fbit};
                    push_data.back_bits  = {8'd0, bbit, 8'd0};
                end
                GRP_RED:
                begin
                    push_data.front_bits = {fbit, 16'd0};
                    push_data.back_bits  = {bbit, 16'd0};
                end
                default:
                begin
                    push_data.front_bits = {8'd0, fbit, 8'd0};
                    push_data.back_bits  = {8'd0, bbit, 8'd0};
                end
            endcase
        end
    end

    assign push_valid = s3_valid_reg;

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && !push_ready) |=> (s3_valid_reg && $stable(s3_qz_reg)
                                           && $stable(s3_req_reg)))
        else $error("front output changed while stalled");

    a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy |-> !in_fire)
        else $error("request taken during store clearing");

    a_pipe_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s2_valid_reg) |=> s3_valid_reg)
        else $error("item lost between stages");

endmodule

// ----- hw/rtl/vbp_queue.sv -----
// vbp_queue: short command queue between the request pipeline and the store
// access unit; depends on vbp_pkg
`timescale 1ns / 1ps

module vbp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  vbp_pkg::cmd_t  push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output vbp_pkg::cmd_t  pop_data
);

    localparam int QW = $clog2(vbp_pkg::QUEUE_DEPTH);
    localparam logic [QW-1:0] LAST_SLOT = QW'(vbp_pkg::QUEUE_DEPTH - 1);
    localparam logic [QW:0]   FULL_CNT  = (QW + 1)'(vbp_pkg::QUEUE_DEPTH);

    vbp_pkg::cmd_t  entry_reg [vbp_pkg::QUEUE_DEPTH];
    logic [QW-1:0]  wr_ptr_reg;
    logic [QW-1:0]  rd_ptr_reg;
    logic [QW:0]    count_reg;
    logic [QW:0]    count_next;
    logic           push_fire;
    logic           pop_fire;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_fire && !push_fire)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push_fire)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop_fire)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hw/rtl/vbp_back.sv -----
// vbp_back: front and back pixel stores with clearing pass, read-modify-write
// sequencer and result register; depends on vbp_pkg
`timescale 1ns / 1ps

module vbp_back #(
    parameter int GRID_X = vbp_pkg::GRID_X_DEFAULT,
    parameter int GRID_Y = vbp_pkg::GRID_Y_DEFAULT,
    parameter int SLICES = vbp_pkg::SLICES_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pop_valid,
    output logic                          pop_ready,
    input  vbp_pkg::cmd_t                 pop_data,
    output logic                          clear_busy,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_plotted,
    output logic [vbp_pkg::WORD_W-1:0]    out_front,
    output logic [vbp_pkg::WORD_W-1:0]    out_back
);

    localparam int WORDS = SLICES * GRID_Y * GRID_X;
    localparam int AW    = $clog2(WORDS);
    localparam int DW    = vbp_pkg::WORD_W;
    localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

    vbp_pkg::back_state_t  state_reg;
    vbp_pkg::back_state_t  state_next;
    logic [AW-1:0]         clr_cnt_reg;
    logic [AW-1:0]         clr_cnt_next;
    vbp_pkg::cmd_t         cmd_reg;

    logic [DW-1:0]         front_ram [WORDS];
    logic [DW-1:0]         back_ram  [WORDS];
    logic [DW-1:0]         front_rd_reg;
    logic [DW-1:0]         back_rd_reg;

    logic                  pop_fire;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DW-1:0]         wr_front;
    logic [DW-1:0]         wr_back;

    logic                  load_out;
    logic                  load_plotted;
    logic [DW-1:0]         load_front;
    logic [DW-1:0]         load_back;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  out_plotted_reg;
    logic [DW-1:0]         out_front_reg;
    logic [DW-1:0]         out_back_reg;

    assign pop_fire = pop_valid && pop_ready;

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            vbp_pkg::BK_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_WORD)
                begin
                    state_next = vbp_pkg::BK_IDLE;
                end
            end
            vbp_pkg::BK_IDLE:
            begin
                if (pop_fire && (pop_data.kind != vbp_pkg::CMD_ZERO))
                begin
                    state_next = vbp_pkg::BK_ACCESS;
                end
            end
            vbp_pkg::BK_ACCESS:
            begin
                state_next = vbp_pkg::BK_IDLE;
            end
            default:
            begin
                state_next = vbp_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop_ready    = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = pop_data.addr[AW-1:0];
        wr_en        = 1'b0;
        wr_addr      = clr_cnt_reg;
        wr_front     = '0;
        wr_back      = '0;
        load_out     = 1'b0;
        load_plotted = 1'b0;
        load_front   = '0;
        load_back    = '0;
        case (state_reg)
            vbp_pkg::BK_CLEAR:
            begin
                wr_en = 1'b1;
            end
            vbp_pkg::BK_IDLE:
            begin
                pop_ready = !out_valid_reg || out_ready;
                rd_en     = pop_fire && (pop_data.kind != vbp_pkg::CMD_ZERO);
                load_out  = pop_fire && (pop_data.kind == vbp_pkg::CMD_ZERO);
            end
            vbp_pkg::BK_ACCESS:
            begin
                // read commands carry empty masks, so the merge is a plain read
                load_out     = 1'b1;
                load_plotted = (cmd_reg.kind == vbp_pkg::CMD_PLOT);
                load_front   = front_rd_reg | cmd_reg.front_bits;
                load_back    = back_rd_reg | cmd_reg.back_bits;
                wr_en        = (cmd_reg.kind == vbp_pkg::CMD_PLOT);
                wr_addr      = cmd_reg.addr[AW-1:0];
                wr_front     = load_front;
                wr_back      = load_back;
            end
            default:
            begin
                pop_ready = 1'b0;
            end
        endcase
    end

    assign out_valid_next = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vbp_pkg::BK_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_fire)
        begin
            cmd_reg <= pop_data;
        end
        if (load_out)
        begin
            out_plotted_reg <= load_plotted;
            out_front_reg   <= load_front;
            out_back_reg    <= load_back;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            front_ram[wr_addr] <= wr_front;
            back_ram[wr_addr]  <= wr_back;
        end
        if (rd_en)
        begin
            front_rd_reg <= front_ram[rd_addr];
            back_rd_reg  <= back_ram[rd_addr];
        end
    end

    assign clear_busy  = (state_reg == vbp_pkg::BK_CLEAR);
    assign out_valid   = out_valid_reg;
    assign out_plotted = out_plotted_reg;
    assign out_front   = out_front_reg;
    assign out_back    = out_back_reg;

    a_access_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vbp_pkg::BK_ACCESS) |=> (state_reg == vbp_pkg::BK_IDLE))
        else $error("access state held longer than one cycle");

    a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vbp_pkg::BK_ACCESS) |-> !out_valid_reg)
        else $error("result would overwrite an untaken result");

    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> ((state_reg == vbp_pkg::BK_CLEAR)
                   || (cmd_reg.kind == vbp_pkg::CMD_PLOT)))
        else $error("store written outside clearing or plot");

    a_plot_from_access: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid_reg) && out_plotted_reg)
            |-> ($past(state_reg) == vbp_pkg::BK_ACCESS))
        else $error("plotted result without store access");

endmodule

// ----- hw/rtl/voxel_bitplane_plotter_core.sv -----
// voxel_bitplane_plotter_core: top level - configuration registers, request
// pipeline, command queue and store access; depends on vbp_pkg, vbp_front,
// vbp_queue and vbp_back
//
// channel   direction  transfer when           payload
// in        in         in_valid & in_ready     req_type, coord_x/y/z, read_slice/col/row
// out       out        out_valid & out_ready   plotted, front_word, back_word
// cfg       in         cfg_valid & cfg_ready   cfg_index, cfg_data
//
// three pipeline stages (swap and capture, offset subtract, 32x32 scale multiply)
// feed a four-entry command queue; the store unit handles an item that touches the
// stores as a registered read, then a merge and write, and answers any other item
// straight from idle, taking no new item until it is back in idle; a result leaves
// through the output register after the stage registers, the queue and, for a store
// access, the read register; after reset a clearing pass writes zero over all
// SLICES*GRID_Y*GRID_X words (49152 by default); in_ready stays low until it ends, cfg is always taken
// either side may stall on its own; the queue and result register absorb it
`timescale 1ns / 1ps

module voxel_bitplane_plotter_core #(
    parameter int GRID_X = vbp_pkg::GRID_X_DEFAULT,
    parameter int GRID_Y = vbp_pkg::GRID_Y_DEFAULT,
    parameter int SLICES = vbp_pkg::SLICES_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  req_type,
    input  logic signed [31:0]    coord_x,
    input  logic signed [31:0]    coord_y,
    input  logic signed [31:0]    coord_z,
    input  logic [1:0]            read_slice,
    input  logic [6:0]            read_col,
    input  logic [6:0]            read_row,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  plotted,
    output logic [23:0]           front_word,
    output logic [23:0]           back_word,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [31:0]           cfg_data
);

    logic signed [31:0]  offset_x_reg;
    logic signed [31:0]  offset_y_reg;
    logic signed [31:0]  offset_z_reg;
    logic [31:0]         scale_x_reg;
    logic [31:0]         scale_y_reg;
    logic [31:0]         scale_z_reg;
    logic [2:0]          swap_mode_reg;
    logic [2:0]          flip_mode_reg;

    logic                clear_busy;
    logic                push_valid;
    logic                push_ready;
    vbp_pkg::cmd_t       push_data;
    logic                pop_valid;
    logic                pop_ready;
    vbp_pkg::cmd_t       pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg  <= '0;
            offset_y_reg  <= '0;
            offset_z_reg  <= '0;
            scale_x_reg   <= vbp_pkg::SCALE_RESET;
            scale_y_reg   <= vbp_pkg::SCALE_RESET;
            scale_z_reg   <= vbp_pkg::SCALE_RESET;
            swap_mode_reg <= '0;
            flip_mode_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (vbp_pkg::cfg_index_t'(cfg_index))
                vbp_pkg::CFG_OFFSET_X:  offset_x_reg  <= cfg_data;
                vbp_pkg::CFG_OFFSET_Y:  offset_y_reg  <= cfg_data;
                vbp_pkg::CFG_OFFSET_Z:  offset_z_reg  <= cfg_data;
                vbp_pkg::CFG_SCALE_X:   scale_x_reg   <= cfg_data;
                vbp_pkg::CFG_SCALE_Y:   scale_y_reg   <= cfg_data;
                vbp_pkg::CFG_SCALE_Z:   scale_z_reg   <= cfg_data;
                vbp_pkg::CFG_SWAP_MODE: swap_mode_reg <= cfg_data[2:0];
                vbp_pkg::CFG_FLIP_MODE: flip_mode_reg <= cfg_data[2:0];
                default:                swap_mode_reg <= swap_mode_reg;
            endcase
        end
    end

    vbp_front #(
        .GRID_X (GRID_X),
        .GRID_Y (GRID_Y),
        .SLICES (SLICES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .coord_x    (coord_x),
        .coord_y    (coord_y),
        .coord_z    (coord_z),
        .read_slice (read_slice),
        .read_col   (read_col),
        .read_row   (read_row),
        .offset_x   (offset_x_reg),
        .offset_y   (offset_y_reg),
        .offset_z   (offset_z_reg),
        .scale_x    (scale_x_reg),
        .scale_y    (scale_y_reg),
        .scale_z    (scale_z_reg),
        .swap_mode  (swap_mode_reg),
        .flip_mode  (flip_mode_reg),
        .clear_busy (clear_busy),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    vbp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    vbp_back #(
        .GRID_X (GRID_X),
        .GRID_Y (GRID_Y),
        .SLICES (SLICES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_data    (pop_data),
        .clear_busy  (clear_busy),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_plotted (plotted),
        .out_front   (front_word),
        .out_back    (back_word)
    );

endmodule
